@@ hw/rtl/sorted_deadline_timer_queue_defines.svh @@
// assertion macros for the timer queue checker
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SDTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SDTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sdtq_pkg.sv @@
// types and constants of the sorted deadline timer queue
package sdtq_pkg;

  localparam int unsigned SEC_W    = 33;
  localparam int unsigned USEC_W   = 20;
  localparam int unsigned TMO_W    = 31;
  localparam int unsigned RID_W    = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned QUO_W    = 22;
  localparam int unsigned REM_W    = 10;
  localparam int unsigned PROD_W   = 57;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
  localparam logic [REM_W-1:0]  MS_PER_SEC   = 10'd1000;

  // floor(2^35 / 125): quotient of (timeout >> 3) / 125, low by at most one
  localparam int unsigned       RECIP_SHIFT = 35;
  localparam logic [28:0]       RECIP_125   = 29'd274877906;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DIV_MUL,
    FSM_DIV_FIX,
    FSM_DEADLINE,
    FSM_WALK_INS,
    FSM_PLACE,
    FSM_WALK_DEL,
    FSM_QUERY,
    FSM_RESP
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [31:0]        now_sec;
    logic [USEC_W-1:0]  now_usec;
    logic [TMO_W-1:0]   timeout_ms;
    logic [RID_W-1:0]   request_id;
    logic [TAG_W-1:0]   user_tag;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [RID_W-1:0]   out_request_id;
    logic [TAG_W-1:0]   out_tag;
    logic [SEC_W-1:0]   time_sec;
    logic [USEC_W-1:0]  time_usec;
  } out_item_t;

  typedef struct packed {
    logic [SEC_W-1:0]   sec;
    logic [USEC_W-1:0]  usec;
  } stamp_t;

  typedef struct packed {
    logic   neg;
    stamp_t diff;
  } alu_res_t;

endpackage

@@ hw/rtl/sdtq_ram.sv @@
// generic single write, single read ram with registered read data
module sdtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sdtq_time_alu.sv @@
// shared timestamp subtractor: a minus b with microsecond borrow
module sdtq_time_alu import sdtq_pkg::*; (
  input  stamp_t   a_i,
  input  stamp_t   b_i,
  output alu_res_t res_o
);

  logic [USEC_W:0]   usec_raw;
  logic              borrow;
  logic [USEC_W-1:0] usec_fix;
  logic [SEC_W:0]    sec_raw;

  always_comb begin
    usec_raw = {1'b0, a_i.usec} - {1'b0, b_i.usec};
    borrow   = usec_raw[USEC_W];
    // wraps back into 0..999999 when borrowing
    usec_fix = borrow ? (usec_raw[USEC_W-1:0] + USEC_PER_SEC) : usec_raw[USEC_W-1:0];
    sec_raw  = {1'b0, a_i.sec} - {1'b0, b_i.sec} - {{SEC_W{1'b0}}, borrow};
    res_o.neg       = sec_raw[SEC_W];
    res_o.diff.sec  = sec_raw[SEC_W-1:0];
    res_o.diff.usec = usec_fix;
  end

endmodule

@@ hw/rtl/sorted_deadline_timer_queue.sv @@
// Sorted deadline timer queue. Holds up to QUEUE_DEPTH records (deadline as seconds and
// microseconds, request id, tag) in one ram, kept in ascending deadline order; equal
// deadlines keep arrival order. One operation is in flight at a time and in_stall_o is
// high from the beat after acceptance until the block is back in idle. Every operation
// gives exactly one result beat. The ram has one read and one write port, and a small
// sequencer walks the records through it one entry per cycle, with one shared timestamp
// subtractor doing every deadline compare and the remaining-time calculation. Insert divides
// the timeout, forms the deadline and walks back from the tail over the records past the new
// deadline position; pop and remove walk every record; query reads only the head; an
// operation answered at once (full, empty, not found on an empty queue) goes straight to the
// result. The result register lets the next operation be taken while a result beat still
// waits on out_stall_i. The ram needs no clearing after reset: only entries below the fill
// count are ever used.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned IdKeep = (ID_BITS < RID_W) ? ID_BITS : RID_W;
  localparam int unsigned StampW = $bits(stamp_t);
  localparam int unsigned EntW   = StampW + ID_BITS + TAG_W;

  // sequencer state
  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;

  // operation held for the whole walk
  op_e               op_q;
  stamp_t            now_q;
  logic [TMO_W-1:0]  tmo_q;
  logic [ID_BITS-1:0] rid_q;
  logic [TAG_W-1:0]  tag_q;

  // deadline arithmetic
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  stamp_t            new_q, new_d;

  // result staging and output register
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;

  // ram ports
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntW-1:0]   ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [EntW-1:0]   ram_rdata;

  // shared subtractor
  stamp_t            alu_a, alu_b;
  alu_res_t          alu_res;

  logic              in_acc;
  logic              out_free;
  logic [IdxW-1:0]   last_idx;
  logic              at_last;
  stamp_t            rd_stamp;
  logic [ID_BITS-1:0] rd_id;
  logic [TAG_W-1:0]  rd_tag;
  logic [EntW-1:0]   new_entry;
  logic              del_match;

  // arithmetic temporaries
  logic [QUO_W-1:0]  q_est;
  logic [31:0]       q_times;
  logic [31:0]       rem_raw;
  logic [USEC_W-1:0] rem_us;
  logic [USEC_W:0]   us_sum;
  logic              us_carry;

  sdtq_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sdtq_time_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  // result register takes a new beat when empty or when its beat leaves now
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign last_idx  = IdxW'(cnt_q - 1'b1);
  assign at_last   = (idx_q == last_idx);

  // record layout in the ram: deadline, id, tag
  assign rd_stamp  = stamp_t'(ram_rdata[EntW-1 -: StampW]);
  assign rd_id     = ram_rdata[TAG_W +: ID_BITS];
  assign rd_tag    = ram_rdata[TAG_W-1:0];
  assign new_entry = {new_q, rid_q, tag_q};

  // pop always takes the head, remove the first id match in deadline order
  assign del_match = (op_q == OP_POP) ? (idx_q == '0) : (rd_id == rid_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          unique case (in_item_i.op)
            OP_INSERT: state_d = (cnt_q == CntW'(QUEUE_DEPTH)) ? FSM_RESP : FSM_DIV_MUL;
            OP_POP:    state_d = (cnt_q == '0) ? FSM_RESP : FSM_WALK_DEL;
            OP_REMOVE: state_d = (cnt_q == '0) ? FSM_RESP : FSM_WALK_DEL;
            OP_QUERY:  state_d = (cnt_q == '0) ? FSM_RESP : FSM_QUERY;
            default:   state_d = FSM_IDLE;
          endcase
        end
      end
      FSM_DIV_MUL:  state_d = FSM_DIV_FIX;
      FSM_DIV_FIX:  state_d = FSM_DEADLINE;
      FSM_DEADLINE: state_d = (cnt_q == '0) ? FSM_PLACE : FSM_WALK_INS;
      FSM_WALK_INS: begin
        if (!alu_res.neg) begin
          state_d = FSM_RESP;
        end else if (idx_q == '0) begin
          state_d = FSM_PLACE;
        end
      end
      FSM_PLACE:    state_d = FSM_RESP;
      FSM_WALK_DEL: begin
        if (at_last) begin
          state_d = FSM_RESP;
        end
      end
      FSM_QUERY:    state_d = FSM_RESP;
      FSM_RESP: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default:      state_d = FSM_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    found_d     = found_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    new_d       = new_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    alu_a       = new_q;
    alu_b       = rd_stamp;

    q_est    = prod_q[RECIP_SHIFT +: QUO_W];
    q_times  = 32'(q_est) * 32'(MS_PER_SEC);
    rem_raw  = {1'b0, tmo_q} - q_times;
    rem_us   = USEC_W'(rem_q) * USEC_W'(MS_PER_SEC);
    us_sum   = {1'b0, now_q.usec} + {1'b0, rem_us};
    us_carry = (us_sum >= {1'b0, USEC_PER_SEC});

    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          found_d = 1'b0;
          idx_d   = '0;
          unique case (in_item_i.op)
            OP_INSERT: begin
              if (cnt_q == CntW'(QUEUE_DEPTH)) begin
                res_d.status = ST_FULL;
              end
            end
            OP_POP, OP_QUERY: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                res_d.status = ST_NOT_FOUND;
              end
            end
            default: res_d.status = ST_OK;
          endcase
        end
      end
      FSM_DIV_MUL: begin
        // timeout / 1000 = (timeout >> 3) / 125 by reciprocal
        prod_d = PROD_W'(tmo_q[TMO_W-1:3]) * PROD_W'(RECIP_125);
      end
      FSM_DIV_FIX: begin
        // estimate is at most one low: one compare and subtract
        if (rem_raw[REM_W:0] >= {1'b0, MS_PER_SEC}) begin
          quo_d = q_est + 1'b1;
          rem_d = REM_W'(rem_raw[REM_W:0] - {1'b0, MS_PER_SEC});
        end else begin
          quo_d = q_est;
          rem_d = rem_raw[REM_W-1:0];
        end
      end
      FSM_DEADLINE: begin
        new_d.usec = us_carry ? USEC_W'(us_sum - {1'b0, USEC_PER_SEC}) : us_sum[USEC_W-1:0];
        new_d.sec  = now_q.sec + SEC_W'(quo_q) + SEC_W'(us_carry);
        // start the walk at the tail
        ram_raddr  = last_idx;
        idx_d      = last_idx;
      end
      FSM_WALK_INS: begin
        // new at or after the entry read: it goes just behind it
        ram_we    = 1'b1;
        ram_waddr = IdxW'(idx_q + 1'b1);
        if (!alu_res.neg) begin
          ram_wdata = new_entry;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          ram_wdata = ram_rdata;
          if (idx_q != '0) begin
            ram_raddr = idx_q - 1'b1;
            idx_d     = idx_q - 1'b1;
          end
        end
      end
      FSM_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_entry;
        cnt_d     = cnt_q + 1'b1;
      end
      FSM_WALK_DEL: begin
        if (found_q) begin
          // close the gap: move entry down by one
          ram_we    = 1'b1;
          ram_waddr = idx_q - 1'b1;
          ram_wdata = ram_rdata;
        end else if (del_match) begin
          found_d = 1'b1;
          if (op_q == OP_POP) begin
            res_d.out_request_id = RID_W'(rd_id[IdKeep-1:0]);
            res_d.out_tag        = rd_tag;
            res_d.time_sec       = rd_stamp.sec;
            res_d.time_usec      = rd_stamp.usec;
          end
        end
        if (at_last) begin
          if (found_q || del_match) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end else begin
          ram_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      FSM_QUERY: begin
        alu_a = rd_stamp;
        alu_b = now_q;
        if (alu_res.neg) begin
          // deadline already past
          res_d.time_sec  = '0;
          res_d.time_usec = USEC_W'(1);
        end else begin
          res_d.time_sec  = alu_res.diff.sec;
          res_d.time_usec = alu_res.diff.usec;
        end
      end
      FSM_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_item_i.op;
      now_q    <= '{sec:  {1'b0, in_item_i.now_sec},
                    usec: (in_item_i.now_usec > USEC_MAX) ? USEC_MAX : in_item_i.now_usec};
      tmo_q    <= in_item_i.timeout_ms;
      rid_q    <= ID_BITS'(in_item_i.request_id[IdKeep-1:0]);
      tag_q    <= in_item_i.user_tag;
    end
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    new_q  <= new_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

@@ hw/rtl/sdtq_checker.sv @@
// port-level checks of the timer queue and their bind
`include "sorted_deadline_timer_queue_defines.svh"

module sdtq_checker import sdtq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_item_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_i;
  assign out_acc = out_valid_i && !out_stall_i;

  // items taken whose result beat has not left yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending_q <= pending_q + 1'b1;
        2'b01:   pending_q <= pending_q - 1'b1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  `SDTQ_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_item_i), "stalled result beat changed")
  `SDTQ_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall_i, "input taken again without a busy cycle")
  `SDTQ_ASSERT_IMP(a_no_spurious_result, $rose(out_valid_i), pending_q != 2'd0, "result beat with no operation outstanding")
  `SDTQ_ASSERT_IMP(a_two_pending_stall, pending_q == 2'd2, in_stall_i, "third operation could be taken")
  `SDTQ_ASSERT_IMP(a_error_fields_zero, out_valid_i && (out_item_i.status != ST_OK), (out_item_i.out_request_id == '0) && (out_item_i.out_tag == '0) && (out_item_i.time_sec == '0) && (out_item_i.time_usec == '0), "error beat carries data")

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);
